// ----- design/svb_pkg.sv -----
// Shared constants, types and build-time tables of the sine voice bank.
`timescale 1ns / 1ps
package svb_pkg;

   // Bank configuration.
   localparam int AUDIO_RATE_HZ    = 48000;
   localparam int NUM_KEYS         = 128;
   localparam int SINE_TABLE_DEPTH = 1024;

   // Field widths fixed by the interface.
   localparam int MODE_W   = 2;
   localparam int KEY_W    = 7;
   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 32;

   // Derived widths.
   localparam int KEY_ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int ACC_W      = 40;

   // Fixed-point constants.
   localparam longint unsigned PI_Q30     = 64'd3373259426;
   localparam longint unsigned RATIO1_Q30 = 64'd1137589835;
   localparam int              GAIN_Q15   = 6554;
   localparam int              FULL_SCALE = 32767;

   // Queue depths.
   localparam int CMDQ_DEPTH = 2;
   localparam int OUTQ_DEPTH = 2;

   // Input mode codes.
   localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

   // Command operations passed from the front to the back.
   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TICK     = 2'd2
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [KEY_ADDR_W-1:0] key;
   } cmd_type;

   // Command channel between front and back.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef logic [PHASE_W-1:0] inc_table_type  [0:NUM_KEYS-1];
   typedef logic [15:0]        sine_table_type [0:SINE_TABLE_DEPTH];

   // Unsigned restoring division, used only while the tables are built.
   function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Equal-tempered phase increments, one per key.
   function automatic inc_table_type build_increments();
      longint unsigned ratio [0:11];
      longint unsigned num;
      longint unsigned sr;
      longint unsigned inc;
      longint unsigned d;
      int              e;
      int              n;
      int              note;
      int              octave;
      inc_table_type   tab;
      ratio[0] = 64'd1 << 30;
      ratio[1] = RATIO1_Q30;
      for (n = 2; n < 12; n++) begin
         ratio[n] = (ratio[n-1] * RATIO1_Q30 + (64'd1 << 29)) >> 30;
      end
      sr = 64'(AUDIO_RATE_HZ);
      // Key 0 sits at note 3 of octave 4 when counted from 120 below key 69.
      note   = 3;
      octave = 4;
      for (n = 0; n < NUM_KEYS; n++) begin
         e   = octave - 8;
         num = 64'd440 * ratio[note];
         if (e >= 0) begin
            inc = udiv((num << e) + (sr >> 1), sr);
         end else begin
            d   = sr << (-e);
            inc = udiv(num + (d >> 1), d);
         end
         tab[n] = inc[31:0];
         if (note == 11) begin
            note   = 0;
            octave = octave + 1;
         end else begin
            note = note + 1;
         end
      end
      return tab;
   endfunction

   // Quarter-wave sine table from a truncated Taylor series in Q30.
   function automatic sine_table_type build_sine();
      longint unsigned x;
      longint unsigned term;
      longint          s;
      longint          q;
      longint unsigned depth;
      int              i;
      int              k;
      sine_table_type  tab;
      depth = 64'(SINE_TABLE_DEPTH);
      for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = udiv(PI_Q30 * 64'(i) + depth, depth << 1);
         term = x;
         s    = longint'(x);
         for (k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = udiv((term * x) >> 30, 64'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) begin
               s = s - longint'(term);
            end else begin
               s = s + longint'(term);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         q = (s + 16384) >>> 15;
         if (q > 32767) begin
            q = 32767;
         end
         tab[i] = q[15:0];
      end
      return tab;
   endfunction

   localparam inc_table_type  INC_TABLE  = build_increments();
   localparam sine_table_type SINE_TABLE = build_sine();

endpackage

// ----- design/svb_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module svb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/svb_front.sv -----
// Input decoder and command queue of the sine voice bank.
`timescale 1ns / 1ps
module svb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [svb_pkg::MODE_W-1:0]  req_mode,
   input  logic [svb_pkg::KEY_W-1:0]   req_key,
   output svb_pkg::cmd_chan_type       cmd_chan,
   input  logic                        cmd_pop
);
   import svb_pkg::*;

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          slot_ff [0:CMDQ_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             key_ok;
   logic             enq;
   logic             deq;
   cmd_type          cmd_dec;

   // Classify the incoming item; unused modes and keys beyond the bank are dropped.
   always_comb begin
      accept  = req_push && !req_full;
      key_ok  = ({1'b0, req_key} < (KEY_W + 1)'(NUM_KEYS));
      cmd_dec.key = KEY_ADDR_W'(req_key);
      cmd_dec.op  = OP_TICK;
      enq     = 1'b0;
      case (req_mode)
         MODE_NOTE_ON: begin
            cmd_dec.op = OP_NOTE_ON;
            enq        = accept && key_ok;
         end
         MODE_NOTE_OFF: begin
            cmd_dec.op = OP_NOTE_OFF;
            enq        = accept && key_ok;
         end
         MODE_TICK: begin
            cmd_dec.op = OP_TICK;
            enq        = accept;
         end
         default: begin
            enq = 1'b0;
         end
      endcase
   end

   // Queue pointers and fill count.
   always_comb begin
      deq       = cmd_pop && (cnt_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(enq) - CNT_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

   assign req_full       = (cnt_ff == CNT_W'(CMDQ_DEPTH));
   assign cmd_chan.valid = (cnt_ff != '0);
   assign cmd_chan.cmd   = slot_ff[rd_ptr_ff];
endmodule

// ----- design/svb_back.sv -----
// Voice state, tick sweep pipeline and mixer of the sine voice bank.
`timescale 1ns / 1ps
module svb_back (
   input  logic                              clock,
   input  logic                              reset,
   input  svb_pkg::cmd_chan_type             cmd_chan,
   output logic                              cmd_pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [svb_pkg::SAMPLE_W-1:0] out_sample
);
   import svb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SWEEP = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_CLAMP = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   localparam int PROD_W  = 32;
   localparam int SCALE_W = 48;
   localparam int IDXP_W  = 30 + SINE_IDX_W;

   state_type                state_ff, state_in;
   logic [NUM_KEYS-1:0]      active_ff, active_in;
   logic [KEY_ADDR_W-1:0]    key_ff, key_in;

   // Sweep pipeline.
   logic                     p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   logic                     p1_act_ff, p2_act_ff, p3_act_ff, p4_act_ff;
   logic [KEY_ADDR_W-1:0]    p1_key_ff;
   logic [PHASE_W-1:0]       p2_phase_ff;
   logic                     p3_neg_ff;
   logic [15:0]              rom_q_ff;
   logic signed [PROD_W-1:0] p4_prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]       clamp_ff, clamp_in;
   logic signed [SCALE_W-1:0] scale_ff, scale_in;

   logic                     ram_we;
   logic [KEY_ADDR_W-1:0]    ram_waddr;
   logic [PHASE_W-1:0]       ram_wdata;
   logic [PHASE_W-1:0]       ram_rdata;
   logic [PHASE_W-1:0]       phase_new;
   logic [IDXP_W-1:0]        idx_prod;
   logic [SINE_IDX_W-1:0]    idx;
   logic [SINE_IDX_W-1:0]    rom_addr;
   logic signed [16:0]       sine_val;
   logic signed [SCALE_W-1:0] rounded;
   logic                     issue;

   svb_ram #(
      .WIDTH (PHASE_W),
      .DEPTH (NUM_KEYS)
   ) u_phase_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (key_ff),
      .rd_data (ram_rdata)
   );

   // Phase update of the voice whose read data has just arrived.
   assign phase_new = ram_rdata + INC_TABLE[p1_key_ff];

   // Phase RAM write: note-on zeroes a phase, the sweep writes back advanced phases.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = p1_key_ff;
      ram_wdata = phase_new;
      if (p1_vld_ff && p1_act_ff) begin
         ram_we = 1'b1;
      end else if ((state_ff == ST_IDLE) && cmd_chan.valid &&
                   (cmd_chan.cmd.op == OP_NOTE_ON)) begin
         ram_we    = 1'b1;
         ram_waddr = cmd_chan.cmd.key;
         ram_wdata = '0;
      end
   end

   // Table index from the phase: quadrant picks direction and sign.
   always_comb begin
      idx_prod = IDXP_W'(p2_phase_ff[29:0]) * IDXP_W'(SINE_TABLE_DEPTH);
      idx      = idx_prod[30 +: SINE_IDX_W];
      rom_addr = p2_phase_ff[30] ? (SINE_IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
      sine_val = p3_neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});
   end

   // Control sequencer.
   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      key_in    = key_ff;
      cmd_pop   = 1'b0;
      issue     = 1'b0;
      acc_in    = acc_ff;
      clamp_in  = clamp_ff;
      scale_in  = scale_ff;
      out_valid = 1'b0;
      if (p4_vld_ff && p4_act_ff) begin
         acc_in = acc_ff + ACC_W'(p4_prod_ff);
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd_chan.valid) begin
               cmd_pop = 1'b1;
               case (cmd_chan.cmd.op)
                  OP_NOTE_ON: begin
                     active_in[cmd_chan.cmd.key] = 1'b1;
                  end
                  OP_NOTE_OFF: begin
                     active_in[cmd_chan.cmd.key] = 1'b0;
                  end
                  OP_TICK: begin
                     key_in   = '0;
                     acc_in   = '0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            issue = 1'b1;
            if (key_ff == KEY_ADDR_W'(NUM_KEYS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               key_in = key_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff && !p4_vld_ff) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (acc_ff > ACC_W'(64'sd1073741824)) begin
               clamp_in = 32'sd1073741824;
            end else if (acc_ff < -ACC_W'(64'sd1073741824)) begin
               clamp_in = -32'sd1073741824;
            end else begin
               clamp_in = 32'(acc_ff);
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // Full-scale gain of 32767 as a shift by 15 less the value itself.
            scale_in = (SCALE_W'(clamp_ff) <<< 15) - SCALE_W'(clamp_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Truncation toward zero of the scaled sum by 2^30.
   always_comb begin
      rounded    = scale_ff + (scale_ff[SCALE_W-1] ? SCALE_W'(32'h3FFF_FFFF) : '0);
      out_sample = SAMPLE_W'(rounded >>> 30);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= '0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         p1_vld_ff <= issue;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      acc_ff      <= acc_in;
      clamp_ff    <= clamp_in;
      scale_ff    <= scale_in;
      p1_key_ff   <= key_ff;
      p1_act_ff   <= active_ff[key_ff];
      p2_phase_ff <= phase_new;
      p2_act_ff   <= p1_act_ff;
      p3_neg_ff   <= p2_phase_ff[31];
      p3_act_ff   <= p2_act_ff;
      rom_q_ff    <= SINE_TABLE[rom_addr];
      p4_prod_ff  <= PROD_W'(sine_val) * PROD_W'(GAIN_Q15);
      p4_act_ff   <= p3_act_ff;
   end
endmodule

// ----- design/polyphonic_sine_voice_bank_top.sv -----
// Top level of the polyphonic sine voice bank with its result queue.
`timescale 1ns / 1ps
// Usage:
//   The request side is a queue: drive req_mode and req_key and raise req_push
//   while req_full is low. Mode note-on starts a key from phase zero, note-off
//   silences it, and tick mixes all sounding keys into one sample.
//   Note-on and note-off give no result.
//   A tick gives one rsp_sample, read while rsp_empty is low and taken with
//   rsp_pop. From its transfer until its sample waits on rsp_sample, a tick
//   passes these steps: the back end takes the command, the sweep reads one
//   key's phase per cycle from the phase RAM, then the pipeline drain, clamp,
//   scale and the hand-off to the result queue follow.
//   A two-entry command queue decouples the request side from the sweep, so
//   up to two commands are taken while a tick is in progress.
//   Results wait in a two-entry queue; when it is full the back end holds the
//   finished sample and the command queue fills, which raises req_full.
//   Reset clears all voices to silent and empties both queues; no phase
//   clearing pass is needed, since a note-on writes its key's phase.
module polyphonic_sine_voice_bank_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [svb_pkg::MODE_W-1:0]         req_mode,
   input  logic [svb_pkg::KEY_W-1:0]          req_key,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [svb_pkg::SAMPLE_W-1:0] rsp_sample
);
   import svb_pkg::*;

   localparam int OPTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
   localparam int OCNT_W = $clog2(OUTQ_DEPTH + 1);

   cmd_chan_type              cmd_chan;
   logic                      cmd_pop;
   logic                      out_valid;
   logic                      out_ready;
   logic signed [SAMPLE_W-1:0] out_sample;

   logic signed [SAMPLE_W-1:0] outq_ff [0:OUTQ_DEPTH-1];
   logic [OPTR_W-1:0]         owr_ff, owr_in;
   logic [OPTR_W-1:0]         ord_ff, ord_in;
   logic [OCNT_W-1:0]         ocnt_ff, ocnt_in;
   logic                      o_enq;
   logic                      o_deq;

   svb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_mode (req_mode),
      .req_key  (req_key),
      .cmd_chan (cmd_chan),
      .cmd_pop  (cmd_pop)
   );

   svb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_chan   (cmd_chan),
      .cmd_pop    (cmd_pop),
      .out_valid  (out_valid),
      .out_ready  (out_ready),
      .out_sample (out_sample)
   );

   // Result queue control.
   always_comb begin
      out_ready = (ocnt_ff != OCNT_W'(OUTQ_DEPTH));
      o_enq     = out_valid && out_ready;
      o_deq     = rsp_pop && !rsp_empty;
      owr_in    = owr_ff;
      ord_in    = ord_ff;
      if (o_enq) begin
         owr_in = (owr_ff == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_ff + 1'b1;
      end
      if (o_deq) begin
         ord_in = (ord_ff == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_ff + 1'b1;
      end
      ocnt_in = ocnt_ff + OCNT_W'(o_enq) - OCNT_W'(o_deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (o_enq) begin
         outq_ff[owr_ff] <= out_sample;
      end
   end

   assign rsp_empty  = (ocnt_ff == '0);
   assign rsp_sample = outq_ff[ord_ff];

`ifndef ASSERT_OFF
   // The result queue never holds more than its depth.
   a_outq_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OCNT_W'(OUTQ_DEPTH))
      else $error("result queue overfilled");

   // A waiting result never reaches the most negative code after clamping.
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_sample != 16'sh8000)
      else $error("sample outside clamp range");

   // A transfer into the result queue raises its fill count unless one leaves.
   a_outq_count: assert property (@(posedge clock) disable iff (reset)
      (o_enq && !o_deq) |=> ocnt_ff == $past(ocnt_ff) + 1'b1)
      else $error("result queue count mismatch");
`endif
endmodule

// ----- tb/polyphonic_sine_voice_bank_top_tb.sv -----
// Self-checking testbench for the polyphonic sine voice bank top level.
`timescale 1ns / 1ps
module polyphonic_sine_voice_bank_top_tb;
   import svb_pkg::*;

   localparam int KEYS          = 128;
   localparam int TABLE_DEPTH   = 1024;
   localparam int SR            = 48000;
   localparam longint unsigned PI_Q = 64'd3373259426;
   localparam longint unsigned RATIO_STEP = 64'd1137589835;
   localparam longint ONE_Q30   = 64'sd1073741824;
   localparam int DRAIN_CYCLES  = 300;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [1:0]          req_mode;
   logic [6:0]          req_key;
   logic                rsp_empty;
   logic                rsp_pop;
   logic signed [15:0]  rsp_sample;

   // Predictor state: note gates, phase words and the build-time tables.
   logic [31:0] pitch_step [0:KEYS-1];
   logic [15:0] quarter_wave [0:TABLE_DEPTH];
   logic        key_down [0:KEYS-1];
   logic [31:0] key_phase [0:KEYS-1];

   logic signed [15:0] expected_samples [$];
   int  mismatch_count = 0;
   int  sample_count = 0;
   int  tick_count;
   int  item_count;
   int  pop_idle = 0;
   bit  stall_enable;
   longint cycle_count = 0;

   polyphonic_sine_voice_bank_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_sample (rsp_sample)
   );

   // Clock generation.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Fill the pitch increment and quarter sine tables.
   task automatic build_tables();
      longint unsigned ratio [0:11];
      longint unsigned num;
      longint unsigned inc;
      longint unsigned d;
      longint unsigned x;
      longint unsigned term;
      longint          s;
      longint          q;
      int              t;
      int              e;
      ratio[0] = 64'd1 << 30;
      ratio[1] = RATIO_STEP;
      for (int n = 2; n < 12; n++) begin
         ratio[n] = (ratio[n-1] * RATIO_STEP + (64'd1 << 29)) >> 30;
      end
      for (int n = 0; n < KEYS; n++) begin
         t   = n + 51;
         e   = t / 12 - 8;
         num = 64'd440 * ratio[t % 12];
         if (e >= 0) begin
            inc = ((num << e) + SR / 2) / SR;
         end else begin
            d   = 64'(SR) << (-e);
            inc = (num + d / 2) / d;
         end
         pitch_step[n] = inc[31:0];
      end
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         x    = (PI_Q * 64'(i) + TABLE_DEPTH) / (64'd2 * TABLE_DEPTH);
         term = x;
         s    = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               s = s - longint'(term);
            end else begin
               s = s + longint'(term);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         q = (s + 16384) >>> 15;
         if (q > 32767) begin
            q = 32767;
         end
         quarter_wave[i] = q[15:0];
      end
   endtask

   // Quarter-symmetric sine lookup without interpolation.
   function automatic longint wave_value(logic [31:0] phase);
      longint unsigned idx;
      longint          v;
      idx = (64'(phase[29:0]) * TABLE_DEPTH) >> 30;
      if (phase[30]) begin
         v = quarter_wave[TABLE_DEPTH - idx];
      end else begin
         v = quarter_wave[idx];
      end
      return phase[31] ? -v : v;
   endfunction

   // Apply one request to the voice state; a tick queues its mixed sample.
   task automatic predict_voices(logic [1:0] mode, logic [6:0] key);
      longint acc;
      longint smp;
      acc = 0;
      if (mode == MODE_NOTE_ON) begin
         key_down[key]  = 1'b1;
         key_phase[key] = '0;
      end else if (mode == MODE_NOTE_OFF) begin
         key_down[key] = 1'b0;
      end else if (mode == MODE_TICK) begin
         for (int k = 0; k < KEYS; k++) begin
            if (key_down[k]) begin
               key_phase[k] = key_phase[k] + pitch_step[k];
               acc = acc + wave_value(key_phase[k]) * 6554;
            end
         end
         if (acc > ONE_Q30) begin
            acc = ONE_Q30;
         end
         if (acc < -ONE_Q30) begin
            acc = -ONE_Q30;
         end
         smp = (acc * 32767) / ONE_Q30;
         expected_samples.push_back(smp[15:0]);
         tick_count++;
      end
   endtask

   // Send one request, with an optional random idle burst first.
   task automatic send_request(logic [1:0] mode, logic [6:0] key);
      if (stall_enable && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_mode <= mode;
      req_key  <= key;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      predict_voices(mode, key);
      item_count++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Directed: key extremes, every mode, retrigger, spare mode and silent ticks.
   task automatic test_directed();
      send_request(MODE_TICK, 7'd0);
      send_request(MODE_NOTE_OFF, 7'd40);
      send_request(MODE_TICK, 7'h7F);
      send_request(MODE_NOTE_ON, 7'd0);
      send_request(MODE_NOTE_ON, 7'd127);
      send_request(MODE_NOTE_ON, 7'd69);
      send_request(MODE_TICK, 7'd0);
      send_request(MODE_TICK, 7'd55);
      send_request(MODE_NOTE_ON, 7'd69);
      send_request(MODE_TICK, 7'd0);
      send_request(MODE_SPARE, 7'h55);
      send_request(MODE_SPARE, 7'h2A);
      send_request(MODE_NOTE_OFF, 7'd127);
      send_request(MODE_TICK, 7'd0);
      send_request(MODE_NOTE_OFF, 7'd0);
      send_request(MODE_NOTE_OFF, 7'd69);
      send_request(MODE_TICK, 7'd0);
   endtask

   // Loud chords drive the mix into both clamps.
   task automatic test_clamp();
      for (int k = 60; k < 72; k++) begin
         send_request(MODE_NOTE_ON, 7'(k));
      end
      for (int i = 0; i < 40; i++) begin
         send_request(MODE_TICK, 7'($urandom));
      end
      for (int k = 60; k < 72; k++) begin
         send_request(MODE_NOTE_OFF, 7'(k));
      end
   endtask

   // Random notes and ticks; ticks dominate so voices evolve deeply.
   task automatic test_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (i == count / 2) begin
            // Hold the sender until every sample has been read back.
            wait_for_drain();
         end
         if (pick < 20) begin
            send_request(MODE_NOTE_ON, 7'($urandom));
         end else if (pick < 35) begin
            send_request(MODE_NOTE_OFF, 7'($urandom));
         end else if (pick < 38) begin
            send_request(MODE_SPARE, 7'($urandom));
         end else begin
            send_request(MODE_TICK, 7'($urandom));
         end
      end
   endtask

   // Result side: random pop stalls, compare against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected sample %0d with nothing pending", rsp_sample);
            end
         end else begin
            if (rsp_sample !== expected_samples[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Sample %0d: expected %0d, got %0d", sample_count,
                           expected_samples[0], rsp_sample);
               end
            end
            void'(expected_samples.pop_front());
         end
         sample_count++;
      end
   end

   // Random pop stalls, while stall_enable is set, hold rsp_pop low in bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_idle > 0) begin
         rsp_pop  <= 1'b0;
         pop_idle <= pop_idle - 1;
      end else if (stall_enable && $urandom_range(0, 7) == 0) begin
         rsp_pop  <= 1'b0;
         pop_idle <= $urandom_range(0, 4);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_push       = 1'b0;
      req_mode       = '0;
      req_key        = '0;
      tick_count     = 0;
      item_count     = 0;
      stall_enable   = 1'b1;
      build_tables();
      for (int k = 0; k < KEYS; k++) begin
         key_down[k]  = 1'b0;
         key_phase[k] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_clamp();
      test_random(1100);
      // The closing stretch runs without idling on either side.
      stall_enable = 1'b0;
      test_random(250);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests including %0d ticks; checked %0d samples.",
               item_count, tick_count, sample_count);
      $display("Covered key extremes, retrigger, unused mode, silence and clamping.");
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d samples missing", mismatch_count,
                  expected_samples.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
